FILE: rtl/assert_macros.svh
// assertion helpers, clocked on clk_i and off while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge
`define ASSERT_IMPL(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// expression must never be true
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

FILE: rtl/psgf_pkg.sv
`timescale 1ns / 1ps

package psgf_pkg;

  // default parameter values
  localparam int unsigned TimeWidthDef    = 32;
  localparam int unsigned SpeedFracDef    = 8;

  // fixed field widths
  localparam int unsigned NowWidth        = 32;
  localparam int unsigned CfgDataWidth    = 32;
  localparam int unsigned CfgIdxWidth     = 3;
  localparam int unsigned ShrinkWidth     = 7;
  localparam int unsigned StretchWidth    = 4;
  localparam int unsigned SpeedConstWidth = 24;
  localparam int unsigned SpeedWidth      = 16;
  localparam int unsigned HoldWidth       = 4;
  localparam int unsigned PeriodWidth     = 32;
  localparam int unsigned StatusWidth     = 3;
  localparam int unsigned PercentScale    = 100;

  // register reset values
  localparam logic [CfgDataWidth-1:0]    MinIntervalRst = 32'd7000;
  localparam logic [CfgDataWidth-1:0]    GateIntervalRst = 32'd141287;
  localparam logic [ShrinkWidth-1:0]     ShrinkRst      = 7'd85;
  localparam logic [StretchWidth-1:0]    StretchRst     = 4'd3;
  localparam logic [SpeedConstWidth-1:0] SpeedConstRst  = 24'd1412873;
  localparam logic [SpeedWidth-1:0]      DeltaRst       = 16'd1280;
  localparam logic [HoldWidth-1:0]       RejectRst      = 4'd5;
  localparam logic [CfgDataWidth-1:0]    TimeoutRst     = 32'd2000000;

  // configuration register indexes
  typedef enum logic [CfgIdxWidth-1:0] {
    CfgMinInterval  = 3'd0,
    CfgGateInterval = 3'd1,
    CfgShrink       = 3'd2,
    CfgStretch      = 3'd3,
    CfgSpeedConst   = 3'd4,
    CfgDelta        = 3'd5,
    CfgReject       = 3'd6,
    CfgTimeout      = 3'd7
  } cfg_idx_e;

  // event codes of a result
  typedef enum logic [StatusWidth-1:0] {
    StNone     = 3'd0,
    StRefSet   = 3'd1,
    StTooShort = 3'd2,
    StRatio    = 3'd3,
    StUpdated  = 3'd4,
    StHeld     = 3'd5,
    StTimeout  = 3'd6
  } status_e;

  // divider result toward the sequencer
  typedef struct packed {
    logic                  done;
    logic [SpeedWidth-1:0] quot;
  } div_res_t;

endpackage

FILE: rtl/psgf_if.sv
`timescale 1ns / 1ps

// pulse edge or time check request
interface psgf_in_if;
  logic                              valid;
  logic                              ready;
  logic                              mode;
  logic [psgf_pkg::NowWidth-1:0]     now_us;

  modport source (output valid, output mode, output now_us, input ready);
  modport sink   (input valid, input mode, input now_us, output ready);
endinterface

// configuration write request
interface psgf_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [psgf_pkg::CfgIdxWidth-1:0]  addr;
  logic [psgf_pkg::CfgDataWidth-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

// result request
interface psgf_out_if;
  logic                              valid;
  logic                              ready;
  logic [psgf_pkg::SpeedWidth-1:0]   raw_speed;
  logic [psgf_pkg::SpeedWidth-1:0]   filtered_speed;
  logic [psgf_pkg::PeriodWidth-1:0]  period_us;
  logic [psgf_pkg::StatusWidth-1:0]  event_status;
  logic [psgf_pkg::HoldWidth-1:0]    hold_count;

  modport source (output valid, output raw_speed, output filtered_speed, output period_us,
                  output event_status, output hold_count, input ready);
  modport sink   (input valid, input raw_speed, input filtered_speed, input period_us,
                  input event_status, input hold_count, output ready);
endinterface

FILE: rtl/psgf_div.sv
`timescale 1ns / 1ps

// bit-serial restoring divider: (speed_const << frac) / divisor, saturated to 16 bits
module psgf_div #(
  parameter int unsigned TIME_WIDTH      = psgf_pkg::TimeWidthDef,
  parameter int unsigned SPEED_FRAC_BITS = psgf_pkg::SpeedFracDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [psgf_pkg::SpeedConstWidth-1:0] speed_const_i,
  input  logic [TIME_WIDTH-1:0]                divisor_i,
  output psgf_pkg::div_res_t                   res_o
);

  localparam int unsigned QW   = psgf_pkg::SpeedWidth;
  localparam int unsigned DW   = psgf_pkg::SpeedConstWidth + SPEED_FRAC_BITS;
  localparam int unsigned HW   = DW - QW;
  localparam int unsigned RW   = ((TIME_WIDTH > HW) ? TIME_WIDTH : HW) + 1;
  localparam int unsigned CntW = $clog2(QW + 1);

  logic [DW-1:0]   dividend;
  logic [RW-1:0]   hi_ext;
  logic [RW-1:0]   trial;
  logic            fits;
  logic [RW-1:0]   rem_q;
  logic [RW-1:0]   dvsr_q;
  logic [QW-1:0]   lo_q;
  logic [QW-1:0]   quot_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;

  // scaled dividend and first partial remainder
  assign dividend = DW'(speed_const_i) << SPEED_FRAC_BITS;
  assign hi_ext   = RW'(dividend[DW-1:QW]);

  // one quotient bit per cycle
  assign trial = {rem_q[RW-2:0], lo_q[QW-1]};
  assign fits  = (trial >= dvsr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dvsr_q <= '0;
      lo_q   <= '0;
      quot_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        dvsr_q <= RW'(divisor_i);
        if (hi_ext >= RW'(divisor_i)) begin
          // quotient would not fit in 16 bits
          quot_q <= '1;
          done_q <= 1'b1;
        end else begin
          rem_q  <= hi_ext;
          lo_q   <= dividend[QW-1:0];
          quot_q <= '0;
          cnt_q  <= CntW'(QW);
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        rem_q  <= fits ? (trial - dvsr_q) : trial;
        lo_q   <= {lo_q[QW-2:0], 1'b0};
        quot_q <= {quot_q[QW-2:0], fits};
        cnt_q  <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign res_o.done = done_q;
  assign res_o.quot = quot_q;

endmodule

FILE: rtl/pulse_speed_glitch_filter.sv
`timescale 1ns / 1ps
// channel | dir | handshake      | payload
// in_i    | in  | valid / ready  | mode, now_us
// cfg_i   | in  | valid / ready  | addr (register index), data
// out_o   | out | valid / ready  | raw_speed, filtered_speed, period_us, event_status, hold_count
//
// one request at a time. a time check, a first or a too-short edge goes from evaluation to
// finish; a ratio reject passes the serial multiply and ratio check; an accepted edge passes
// the serial multiply (only while the ratio gate is on), ratio check, bit-serial divider (it
// skips its bit loop if the quotient saturates), filter and finish. rst_ni clears all
// measurement state and loads register defaults. a new request is taken while the last result
// still waits; the sequencer stalls in its last state until out_o is free. cfg_i is always ready.

`include "assert_macros.svh"

module pulse_speed_glitch_filter #(
  parameter int unsigned TIME_WIDTH      = psgf_pkg::TimeWidthDef,
  parameter int unsigned SPEED_FRAC_BITS = psgf_pkg::SpeedFracDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  psgf_in_if.sink      in_i,
  psgf_cfg_if.sink     cfg_i,
  psgf_out_if.source   out_o
);

  localparam int unsigned TW      = TIME_WIDTH;
  localparam int unsigned CW      = (TW > psgf_pkg::CfgDataWidth) ? TW : psgf_pkg::CfgDataWidth;
  localparam int unsigned PW      = TW + psgf_pkg::ShrinkWidth;
  localparam int unsigned FW      = TW + psgf_pkg::StretchWidth;
  localparam int unsigned MulCntW = $clog2(psgf_pkg::ShrinkWidth);
  localparam int unsigned SW      = psgf_pkg::SpeedWidth;
  localparam int unsigned HoldW   = psgf_pkg::HoldWidth;

  typedef enum logic [6:0] {
    SIdle   = 7'b0000001,
    SEval   = 7'b0000010,
    SMul    = 7'b0000100,
    SRatio  = 7'b0001000,
    SDiv    = 7'b0010000,
    SFilt   = 7'b0100000,
    SFinish = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [psgf_pkg::CfgDataWidth-1:0]    min_int_q;
  logic [psgf_pkg::CfgDataWidth-1:0]    gate_q;
  logic [psgf_pkg::ShrinkWidth-1:0]     shrink_q;
  logic [psgf_pkg::StretchWidth-1:0]    stretch_q;
  logic [psgf_pkg::SpeedConstWidth-1:0] spd_const_q;
  logic [SW-1:0]                        delta_q;
  logic [HoldW-1:0]                     rej_lim_q;
  logic [psgf_pkg::CfgDataWidth-1:0]    timeout_q;

  // request and measurement state
  logic                  mode_q;
  logic [TW-1:0]         now_q;
  logic [TW-1:0]         last_q;
  logic                  have_ref_q;
  logic [TW-1:0]         valid_q;
  logic [TW-1:0]         period_q;
  logic [SW-1:0]         unf_q;
  logic [SW-1:0]         sm_q;
  logic [HoldW-1:0]      held_q;

  // work registers
  logic [TW-1:0]                    diff_q;
  logic                             chk_q;
  psgf_pkg::status_e                status_q;
  logic [PW-1:0]                    v_sh_q;
  logic [PW-1:0]                    acc_p_q;
  logic [FW-1:0]                    acc_f_q;
  logic [psgf_pkg::ShrinkWidth-1:0] mp_q;
  logic [psgf_pkg::StretchWidth-1:0] mf_q;
  logic [MulCntW-1:0]               mcnt_q;

  // result register
  logic                              out_valid_q;
  logic [SW-1:0]                     out_raw_q;
  logic [SW-1:0]                     out_filt_q;
  logic [psgf_pkg::PeriodWidth-1:0]  out_per_q;
  logic [psgf_pkg::StatusWidth-1:0]  out_stat_q;
  logic [HoldW-1:0]                  out_hold_q;

  logic [TW-1:0]                     diff_w;
  logic                              too_short;
  logic                              gate_on;
  logic                              timed_out;
  logic [PW:0]                       shr_rhs;
  logic                              ratio_bad;
  logic [SW-1:0]                     delta_w;
  logic                              take_new;
  logic                              out_free;
  logic                              div_start;
  logic [CW-1:0]                     per_ext;
  logic [psgf_pkg::PeriodWidth-1:0]  per_out;
  psgf_pkg::div_res_t                div_res;

  // configuration writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_int_q   <= psgf_pkg::MinIntervalRst;
      gate_q      <= psgf_pkg::GateIntervalRst;
      shrink_q    <= psgf_pkg::ShrinkRst;
      stretch_q   <= psgf_pkg::StretchRst;
      spd_const_q <= psgf_pkg::SpeedConstRst;
      delta_q     <= psgf_pkg::DeltaRst;
      rej_lim_q   <= psgf_pkg::RejectRst;
      timeout_q   <= psgf_pkg::TimeoutRst;
    end else if (cfg_i.valid) begin
      case (psgf_pkg::cfg_idx_e'(cfg_i.addr))
        psgf_pkg::CfgMinInterval:  min_int_q   <= cfg_i.data;
        psgf_pkg::CfgGateInterval: gate_q      <= cfg_i.data;
        psgf_pkg::CfgShrink:       shrink_q    <= cfg_i.data[psgf_pkg::ShrinkWidth-1:0];
        psgf_pkg::CfgStretch:      stretch_q   <= cfg_i.data[psgf_pkg::StretchWidth-1:0];
        psgf_pkg::CfgSpeedConst:   spd_const_q <= cfg_i.data[psgf_pkg::SpeedConstWidth-1:0];
        psgf_pkg::CfgDelta:        delta_q     <= cfg_i.data[SW-1:0];
        psgf_pkg::CfgReject:       rej_lim_q   <= cfg_i.data[HoldW-1:0];
        psgf_pkg::CfgTimeout:      timeout_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // interval and length checks
  assign diff_w    = now_q - last_q;
  assign too_short = (diff_w == '0) || (CW'(diff_w) <= CW'(min_int_q));
  assign gate_on   = (valid_q != '0) && (CW'(valid_q) < CW'(gate_q));
  assign timed_out = have_ref_q && (CW'(diff_w) > CW'(timeout_q));

  // ratio checks: diff < floor(v*pct/100) is 100*(diff+1) <= v*pct
  assign shr_rhs   = ((PW+1)'(diff_q) + (PW+1)'(1)) * (PW+1)'(psgf_pkg::PercentScale);
  assign ratio_bad = chk_q && ((shr_rhs <= (PW+1)'(acc_p_q)) || (FW'(diff_q) > acc_f_q));

  // delta filter decision
  assign delta_w  = (unf_q > sm_q) ? (unf_q - sm_q) : (sm_q - unf_q);
  assign take_new = (sm_q == '0) || (delta_w <= delta_q) || (held_q >= rej_lim_q);

  assign out_free  = !out_valid_q || out_o.ready;
  assign div_start = (state_q == SRatio) && !ratio_bad;

  psgf_div #(
    .TIME_WIDTH      (TIME_WIDTH),
    .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
  ) u_div (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (div_start),
    .speed_const_i (spd_const_q),
    .divisor_i     (diff_q),
    .res_o         (div_res)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle:   if (in_i.valid) state_d = SEval;
      SEval: begin
        if (mode_q || !have_ref_q || too_short) state_d = SFinish;
        else if (gate_on)                       state_d = SMul;
        else                                    state_d = SRatio;
      end
      SMul:    if (mcnt_q == '0) state_d = SRatio;
      SRatio:  state_d = ratio_bad ? SFinish : SDiv;
      SDiv:    if (div_res.done) state_d = SFilt;
      SFilt:   state_d = SFinish;
      SFinish: if (out_free) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  assign in_i.ready = (state_q == SIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // measurement datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b0;
      now_q      <= '0;
      last_q     <= '0;
      have_ref_q <= 1'b0;
      valid_q    <= '0;
      period_q   <= '0;
      unf_q      <= '0;
      sm_q       <= '0;
      held_q     <= '0;
      status_q   <= psgf_pkg::StNone;
      chk_q      <= 1'b0;
      diff_q     <= '0;
      v_sh_q     <= '0;
      acc_p_q    <= '0;
      acc_f_q    <= '0;
      mp_q       <= '0;
      mf_q       <= '0;
      mcnt_q     <= '0;
    end else begin
      case (state_q)
        SIdle: begin
          if (in_i.valid) begin
            mode_q <= in_i.mode;
            now_q  <= TW'(in_i.now_us);
          end
        end
        SEval: begin
          chk_q    <= gate_on;
          diff_q   <= diff_w;
          v_sh_q   <= PW'(valid_q);
          acc_p_q  <= '0;
          acc_f_q  <= '0;
          mp_q     <= shrink_q;
          mf_q     <= stretch_q;
          mcnt_q   <= MulCntW'(psgf_pkg::ShrinkWidth - 1);
          if (mode_q) begin
            // time check, no edge for too long
            if (timed_out) begin
              last_q     <= '0;
              have_ref_q <= 1'b0;
              valid_q    <= '0;
              period_q   <= '0;
              unf_q      <= '0;
              sm_q       <= '0;
              held_q     <= '0;
              status_q   <= psgf_pkg::StTimeout;
            end else begin
              status_q   <= psgf_pkg::StNone;
            end
          end else if (!have_ref_q) begin
            have_ref_q <= 1'b1;
            last_q     <= now_q;
            status_q   <= psgf_pkg::StRefSet;
          end else begin
            last_q <= now_q;
            if (too_short) status_q <= psgf_pkg::StTooShort;
            else           status_q <= psgf_pkg::StNone;
          end
        end
        SMul: begin
          // shift-add of the last valid interval by percent and factor
          if (mp_q[0]) acc_p_q <= acc_p_q + v_sh_q;
          if (mf_q[0]) acc_f_q <= acc_f_q + v_sh_q[FW-1:0];
          v_sh_q <= {v_sh_q[PW-2:0], 1'b0};
          mp_q   <= mp_q >> 1;
          mf_q   <= mf_q >> 1;
          mcnt_q <= mcnt_q - MulCntW'(1);
        end
        SRatio: begin
          if (ratio_bad) status_q <= psgf_pkg::StRatio;
        end
        SDiv: begin
          if (div_res.done) begin
            valid_q  <= diff_q;
            period_q <= diff_q;
            unf_q    <= div_res.quot;
          end
        end
        SFilt: begin
          if (take_new) begin
            sm_q     <= unf_q;
            held_q   <= '0;
            status_q <= psgf_pkg::StUpdated;
          end else begin
            if (held_q != '1) held_q <= held_q + HoldW'(1);
            status_q <= psgf_pkg::StHeld;
          end
        end
        default: ;
      endcase
    end
  end

  // period saturated to the output width
  assign per_ext = CW'(period_q);
  assign per_out = (per_ext > CW'({psgf_pkg::PeriodWidth{1'b1}})) ? '1
                                                                  : per_ext[psgf_pkg::PeriodWidth-1:0];

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_raw_q   <= '0;
      out_filt_q  <= '0;
      out_per_q   <= '0;
      out_stat_q  <= '0;
      out_hold_q  <= '0;
    end else begin
      if ((state_q == SFinish) && out_free) begin
        out_valid_q <= 1'b1;
        out_raw_q   <= unf_q;
        out_filt_q  <= sm_q;
        out_per_q   <= per_out;
        out_stat_q  <= status_q;
        out_hold_q  <= held_q;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.raw_speed      = out_raw_q;
  assign out_o.filtered_speed = out_filt_q;
  assign out_o.period_us      = out_per_q;
  assign out_o.event_status   = out_stat_q;
  assign out_o.hold_count     = out_hold_q;

  // checks
  `ASSERT_IMPL(a_accept_eval, in_i.valid && in_i.ready |=> state_q == SEval, "accepted request did not start evaluation")
  `ASSERT_NEVER(a_done_outside_div, div_res.done && (state_q != SDiv), "divider finished outside divide state")
  `ASSERT_IMPL(a_update_tracks, out_valid_q && (out_stat_q == psgf_pkg::StUpdated) |-> out_filt_q == out_raw_q, "updated result with filtered speed apart from raw speed")
  `ASSERT_IMPL(a_timeout_clears, out_valid_q && (out_stat_q == psgf_pkg::StTimeout) |-> (out_raw_q == '0) && (out_filt_q == '0) && (out_hold_q == '0), "timeout result with measurement left")

endmodule
